>>> design/mrcr_pkg.sv
// shared types and constants of the matrix row and column reverser
package mrcr_pkg;

    // widths fixed by the item and register fields
    localparam int CountW = 7;
    localparam int IndexW = 8;
    localparam int ByteW  = 8;
    localparam int CfgIdxW = 1;

    // reset value of both count registers
    localparam logic [CountW-1:0] COUNT_RESET = 7'd64;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_COLUMN_COUNT = 1'b1;

    // operation codes
    typedef enum logic [1:0] {
        OP_WRITE       = 2'd0,
        OP_READ        = 2'd1,
        OP_FLIP_ROW    = 2'd2,
        OP_FLIP_COLUMN = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FLIP_RD,
        S_FLIP_WR,
        S_FLIP_END,
        S_RESULT
    } seq_state_t;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] data;
        logic             bad;
    } res_t;

endpackage

>>> design/mrcr_ram.sv
// generic synchronous ram, one write port and two registered read ports
module mrcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, data registered and ready in the cycle after the address
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

>>> design/mrcr_seq.sv
// sequencer: item decode, cell access and swap walk over the matrix ram
module mrcr_seq #(
    parameter int MAX_DIM = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           op,
    input  logic [mrcr_pkg::IndexW-1:0]          row_index,
    input  logic [mrcr_pkg::IndexW-1:0]          column_index,
    input  logic [mrcr_pkg::ByteW-1:0]           cell_value,
    input  logic [mrcr_pkg::CountW-1:0]          rows,
    input  logic [mrcr_pkg::CountW-1:0]          cols,
    output mrcr_pkg::res_t                       res,
    input  logic                                 res_take,
    output logic                                 ram_we,
    output logic [2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] ram_waddr,
    output logic [mrcr_pkg::ByteW-1:0]           ram_wdata,
    output logic                                 ram_re,
    output logic [2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] ram_raddr_a,
    output logic [2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] ram_raddr_b,
    input  logic [mrcr_pkg::ByteW-1:0]           ram_rdata_a,
    input  logic [mrcr_pkg::ByteW-1:0]           ram_rdata_b
);

    localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = 2 * DW;
    localparam int CW = mrcr_pkg::CountW;
    localparam int XW = (DW > CW) ? DW : CW;

    mrcr_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0]             pair_reg, pair_next;
    logic [CW-1:0]             len_reg, len_next;
    logic [CW-1:0]             half_reg, half_next;
    logic [DW-1:0]             line_reg, line_next;
    logic                      col_flip_reg, col_flip_next;
    logic                      bad_reg, bad_next;
    logic                      rd_sel_reg, rd_sel_next;
    logic [AW-1:0]             hold_addr_reg, hold_addr_next;
    logic [mrcr_pkg::ByteW-1:0] hold_data_reg, hold_data_next;

    logic          accept;
    logic          row_ok;
    logic          col_ok;
    logic [AW-1:0] cell_addr;
    logic [XW-1:0] near_x;
    logic [XW-1:0] far_x;
    logic [AW-1:0] pair_addr_a;
    logic [AW-1:0] pair_addr_b;
    logic          last_pair;
    logic [CW:0]   len_plus;

    assign accept = in_valid && (state_reg == mrcr_pkg::S_IDLE);

    // range checks against the effective counts
    assign row_ok = !row_index[mrcr_pkg::IndexW-1] && (row_index[CW-1:0] < rows);
    assign col_ok = !column_index[mrcr_pkg::IndexW-1] && (column_index[CW-1:0] < cols);
    assign cell_addr = {row_index[DW-1:0], column_index[DW-1:0]};

    // swap pair addresses: near end walks up, far end walks down
    assign near_x = XW'(pair_reg);
    assign far_x  = XW'(CW'(len_reg - pair_reg - CW'(1)));
    assign pair_addr_a = col_flip_reg ? {near_x[DW-1:0], line_reg}
                                      : {line_reg, near_x[DW-1:0]};
    assign pair_addr_b = col_flip_reg ? {far_x[DW-1:0], line_reg}
                                      : {line_reg, far_x[DW-1:0]};
    assign last_pair = ({1'b0, pair_reg} + (CW+1)'(1)) >= {1'b0, half_reg};
    assign len_plus  = {1'b0, (op == mrcr_pkg::OP_FLIP_ROW) ? cols : rows}
                       + (CW+1)'(1);

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mrcr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg      <= pair_next;
        len_reg       <= len_next;
        half_reg      <= half_next;
        line_reg      <= line_next;
        col_flip_reg  <= col_flip_next;
        bad_reg       <= bad_next;
        rd_sel_reg    <= rd_sel_next;
        hold_addr_reg <= hold_addr_next;
        hold_data_reg <= hold_data_next;
    end

    // next state, ram requests and result
    always_comb
    begin
        state_next     = state_reg;
        pair_next      = pair_reg;
        len_next       = len_reg;
        half_next      = half_reg;
        line_next      = line_reg;
        col_flip_next  = col_flip_reg;
        bad_next       = bad_reg;
        rd_sel_next    = rd_sel_reg;
        hold_addr_next = hold_addr_reg;
        hold_data_next = hold_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = cell_addr;
        ram_wdata      = cell_value;
        ram_re         = 1'b0;
        ram_raddr_a    = pair_addr_a;
        ram_raddr_b    = pair_addr_b;
        in_stall       = (state_reg != mrcr_pkg::S_IDLE);
        res.valid      = 1'b0;
        res.data       = rd_sel_reg ? ram_rdata_a : '0;
        res.bad        = bad_reg;

        case (state_reg)
            mrcr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = mrcr_pkg::S_RESULT;
                    bad_next    = 1'b0;
                    rd_sel_next = 1'b0;
                    pair_next   = '0;
                    half_next   = len_plus[CW:1];
                    case (op)
                        mrcr_pkg::OP_WRITE:
                        begin
                            ram_we   = row_ok && col_ok;
                            bad_next = !(row_ok && col_ok);
                        end
                        mrcr_pkg::OP_READ:
                        begin
                            ram_re      = row_ok && col_ok;
                            ram_raddr_a = cell_addr;
                            rd_sel_next = row_ok && col_ok;
                            bad_next    = !(row_ok && col_ok);
                        end
                        mrcr_pkg::OP_FLIP_ROW:
                        begin
                            len_next      = cols;
                            line_next     = row_index[DW-1:0];
                            col_flip_next = 1'b0;
                            if (cols != '0)
                            begin
                                if (row_ok)
                                begin
                                    state_next = mrcr_pkg::S_FLIP_RD;
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                        mrcr_pkg::OP_FLIP_COLUMN:
                        begin
                            len_next      = rows;
                            line_next     = column_index[DW-1:0];
                            col_flip_next = 1'b1;
                            if (rows != '0)
                            begin
                                if (col_ok)
                                begin
                                    state_next = mrcr_pkg::S_FLIP_RD;
                                end
                                else
                                begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            bad_next = 1'b1;
                        end
                    endcase
                end
            end

            // read the pair, finish the far write of the pair before
            mrcr_pkg::S_FLIP_RD:
            begin
                ram_re     = 1'b1;
                ram_we     = (pair_reg != '0);
                ram_waddr  = hold_addr_reg;
                ram_wdata  = hold_data_reg;
                state_next = mrcr_pkg::S_FLIP_WR;
            end

            // near element takes the far byte, far byte write is held
            mrcr_pkg::S_FLIP_WR:
            begin
                ram_we         = 1'b1;
                ram_waddr      = pair_addr_a;
                ram_wdata      = ram_rdata_b;
                hold_addr_next = pair_addr_b;
                hold_data_next = ram_rdata_a;
                if (last_pair)
                begin
                    state_next = mrcr_pkg::S_FLIP_END;
                end
                else
                begin
                    pair_next  = pair_reg + CW'(1);
                    state_next = mrcr_pkg::S_FLIP_RD;
                end
            end

            mrcr_pkg::S_FLIP_END:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hold_addr_reg;
                ram_wdata  = hold_data_reg;
                state_next = mrcr_pkg::S_RESULT;
            end

            // offer the result until the output register takes it
            mrcr_pkg::S_RESULT:
            begin
                res.valid = 1'b1;
                if (res_take)
                begin
                    state_next = mrcr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mrcr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> design/matrix_row_column_reverser.sv
// top level: configuration registers, matrix ram, sequencer and output register
// result path: a cell access result is offered by the sequencer in the cycle after its
//   transfer and passes through the output register before its output transfer
// flow: one item at a time, the input stalled until the result is taken; a flip walks
//   its swap pairs in turn, read then write, on the single ram write port
// reset: control state clears and both counts go to 64; the matrix ram is not cleared
//   and a cell holds its value only once written
module matrix_row_column_reverser #(
    parameter int MAX_DIM = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     op,
    input  logic [mrcr_pkg::IndexW-1:0]    row_index,
    input  logic [mrcr_pkg::IndexW-1:0]    column_index,
    input  logic [mrcr_pkg::ByteW-1:0]     cell_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mrcr_pkg::ByteW-1:0]     read_data,
    output logic                           bad_index,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mrcr_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [mrcr_pkg::CountW-1:0]    cfg_data
);

    localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = 2 * DW;
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = mrcr_pkg::CountW;

    logic [CW-1:0] row_count_reg, row_count_next;
    logic [CW-1:0] column_count_reg, column_count_next;
    logic          out_valid_reg, out_valid_next;
    logic [mrcr_pkg::ByteW-1:0] read_data_reg, read_data_next;
    logic          bad_index_reg, bad_index_next;

    logic [CW-1:0] rows_eff;
    logic [CW-1:0] cols_eff;
    mrcr_pkg::res_t res;
    logic          res_take;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [mrcr_pkg::ByteW-1:0] ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr_a;
    logic [AW-1:0]              ram_raddr_b;
    logic [mrcr_pkg::ByteW-1:0] ram_rdata_a;
    logic [mrcr_pkg::ByteW-1:0] ram_rdata_b;

    // configuration writes, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                mrcr_pkg::REG_ROW_COUNT:    row_count_next    = cfg_data;
                mrcr_pkg::REG_COLUMN_COUNT: column_count_next = cfg_data;
                default:                    row_count_next    = row_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= mrcr_pkg::COUNT_RESET;
            column_count_reg <= mrcr_pkg::COUNT_RESET;
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
        end
    end

    // counts above the matrix size act as the matrix size
    assign rows_eff = ((CW+2)'(row_count_reg) > (CW+2)'(MAX_DIM)) ? CW'(MAX_DIM)
                                                                  : row_count_reg;
    assign cols_eff = ((CW+2)'(column_count_reg) > (CW+2)'(MAX_DIM)) ? CW'(MAX_DIM)
                                                                     : column_count_reg;

    // output register, loads when empty or draining
    assign res_take = res.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        bad_index_next = bad_index_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            read_data_next = res.data;
            bad_index_next = res.bad;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        bad_index_reg <= bad_index_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign bad_index = bad_index_reg;

    // sequencer
    mrcr_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .row_index    (row_index),
        .column_index (column_index),
        .cell_value   (cell_value),
        .rows         (rows_eff),
        .cols         (cols_eff),
        .res          (res),
        .res_take     (res_take),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr_a  (ram_raddr_a),
        .ram_raddr_b  (ram_raddr_b),
        .ram_rdata_a  (ram_rdata_a),
        .ram_rdata_b  (ram_rdata_b)
    );

    // matrix store, row in the upper address bits
    mrcr_ram #(
        .WIDTH (mrcr_pkg::ByteW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

endmodule

>>> design/mrcr_checker.sv
// port checker for the matrix row and column reverser, with its bind
module mrcr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [mrcr_pkg::ByteW-1:0]  read_data,
    input logic                        bad_index
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(read_data) && $stable(bad_index))
        else $error("result payload changed while stalled");

    // a rejected access never returns data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> read_data == '0)
        else $error("data returned with bad index");

    // one item at a time: input stalls right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is at work");

endmodule

bind matrix_row_column_reverser mrcr_checker u_mrcr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .bad_index (bad_index)
);

>>> dv/tb_top.sv
// testbench for the byte matrix with row and column reversal
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_DIM        = 64;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        mrcr_pkg::op_t                     op;
        logic [mrcr_pkg::IndexW-1:0]       row_idx;
        logic [mrcr_pkg::IndexW-1:0]       col_idx;
        logic [mrcr_pkg::ByteW-1:0]        value;
    } matrix_item_t;

    typedef struct {
        logic [mrcr_pkg::ByteW-1:0] data;
        logic                       bad;
    } cell_result_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [1:0]                    op           = mrcr_pkg::OP_WRITE;
    logic [mrcr_pkg::IndexW-1:0]   row_index    = '0;
    logic [mrcr_pkg::IndexW-1:0]   column_index = '0;
    logic [mrcr_pkg::ByteW-1:0]    cell_value   = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic [mrcr_pkg::ByteW-1:0]    read_data;
    logic                          bad_index;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [mrcr_pkg::CfgIdxW-1:0]  cfg_index    = mrcr_pkg::REG_ROW_COUNT;
    logic [mrcr_pkg::CountW-1:0]   cfg_data     = '0;

    // items waiting to be offered, and results owed by the block
    matrix_item_t pending_items[$];
    cell_result_t expected_results[$];
    matrix_item_t current_item;

    // predicted matrix contents and count registers
    logic [mrcr_pkg::ByteW-1:0]  matrix_copy [MAX_DIM*MAX_DIM];
    logic [mrcr_pkg::CountW-1:0] model_rows;
    logic [mrcr_pkg::CountW-1:0] model_cols;

    // stimulus side view: which cells hold a written byte, and the counts in force
    bit cell_written [MAX_DIM*MAX_DIM];
    int gen_rows = MAX_DIM;
    int gen_cols = MAX_DIM;

    int send_gap;
    int stall_left;
    int idle_cycles;
    int mismatch_count;
    bit quiet_tail;
    bit want_long_hold;
    bit long_hold_done;

    matrix_row_column_reverser #(.MAX_DIM(MAX_DIM)) uut (.*);

    always #2 clk = ~clk;

    // a count above the matrix size acts as the full size
    function automatic int usable_count(logic [mrcr_pkg::CountW-1:0] count_value);
        return (count_value > MAX_DIM) ? MAX_DIM : int'(count_value);
    endfunction

    // k-th element of a row or column line
    function automatic int cell_addr(mrcr_pkg::op_t flip_op, int line, int k);
        return (flip_op == mrcr_pkg::OP_FLIP_ROW) ? line * MAX_DIM + k : k * MAX_DIM + line;
    endfunction

    // expected outcome of one item, updating the predicted matrix
    function automatic cell_result_t apply_item(matrix_item_t it);
        cell_result_t               res;
        int                         r;
        int                         c;
        int                         rows;
        int                         cols;
        int                         line;
        int                         span;
        int                         limit;
        int                         a;
        int                         b;
        int                         k;
        logic [mrcr_pkg::ByteW-1:0] held;
        r        = $signed(it.row_idx);
        c        = $signed(it.col_idx);
        rows     = usable_count(model_rows);
        cols     = usable_count(model_cols);
        res.data = '0;
        res.bad  = 1'b0;
        if (it.op == mrcr_pkg::OP_WRITE || it.op == mrcr_pkg::OP_READ)
        begin
            if (r >= 0 && r < rows && c >= 0 && c < cols)
            begin
                if (it.op == mrcr_pkg::OP_WRITE)
                    matrix_copy[r * MAX_DIM + c] = it.value;
                else
                    res.data = matrix_copy[r * MAX_DIM + c];
            end
            else
                res.bad = 1'b1;
        end
        else
        begin
            // flip row walks along the columns, flip column along the rows
            line  = (it.op == mrcr_pkg::OP_FLIP_ROW) ? r : c;
            span  = (it.op == mrcr_pkg::OP_FLIP_ROW) ? cols : rows;
            limit = (it.op == mrcr_pkg::OP_FLIP_ROW) ? rows : cols;
            if (span != 0)
            begin
                if (line >= 0 && line < limit)
                begin
                    for (k = 0; 2 * k < span; k++)
                    begin
                        a              = cell_addr(it.op, line, k);
                        b              = cell_addr(it.op, line, span - 1 - k);
                        held           = matrix_copy[a];
                        matrix_copy[a] = matrix_copy[b];
                        matrix_copy[b] = held;
                    end
                end
                else
                    res.bad = 1'b1;
            end
        end
        return res;
    endfunction

    // index inside 0..count-1, or one outside it (negative or too large)
    function automatic int pick_index(int count, bit outside);
        if (outside || count == 0)
            return $urandom_range(0, 1) ? -int'($urandom_range(1, 128))
                                        : int'($urandom_range(count, 127));
        return $urandom_range(0, count - 1);
    endfunction

    // queue one item and track which cells it leaves written
    task automatic queue_item(mrcr_pkg::op_t item_op, int r, int c,
                              logic [mrcr_pkg::ByteW-1:0] value);
        matrix_item_t it;
        int           line;
        int           span;
        int           limit;
        int           a;
        int           b;
        int           k;
        bit           held;
        it.op      = item_op;
        it.row_idx = r[mrcr_pkg::IndexW-1:0];
        it.col_idx = c[mrcr_pkg::IndexW-1:0];
        it.value   = value;
        if (item_op == mrcr_pkg::OP_WRITE)
        begin
            if (r >= 0 && r < gen_rows && c >= 0 && c < gen_cols)
                cell_written[r * MAX_DIM + c] = 1'b1;
        end
        else if (item_op != mrcr_pkg::OP_READ)
        begin
            line  = (item_op == mrcr_pkg::OP_FLIP_ROW) ? r : c;
            span  = (item_op == mrcr_pkg::OP_FLIP_ROW) ? gen_cols : gen_rows;
            limit = (item_op == mrcr_pkg::OP_FLIP_ROW) ? gen_rows : gen_cols;
            if (span != 0 && line >= 0 && line < limit)
            begin
                for (k = 0; 2 * k < span; k++)
                begin
                    a               = cell_addr(item_op, line, k);
                    b               = cell_addr(item_op, line, span - 1 - k);
                    held            = cell_written[a];
                    cell_written[a] = cell_written[b];
                    cell_written[b] = held;
                end
            end
        end
        pending_items.push_back(it);
    endtask

    // mostly in-range traffic, a tenth with an index out of range
    task automatic queue_random(int count);
        int            n;
        int            sel;
        int            side;
        int            r;
        int            c;
        int            tries;
        bit            outside;
        bit            in_bounds;
        mrcr_pkg::op_t item_op;
        for (n = 0; n < count; n++)
        begin
            sel     = $urandom_range(0, 99);
            outside = ($urandom_range(0, 9) == 0);
            side    = $urandom_range(0, 1);
            if (sel < 65)
            begin
                item_op = (sel < 35) ? mrcr_pkg::OP_WRITE : mrcr_pkg::OP_READ;
                r = pick_index(gen_rows, outside && side == 0);
                c = pick_index(gen_cols, outside && side == 1);
                // reads only land on cells that hold a written byte
                if (item_op == mrcr_pkg::OP_READ && !outside)
                begin
                    for (tries = 0; tries < 8; tries++)
                    begin
                        in_bounds = (r >= 0 && r < gen_rows && c >= 0 && c < gen_cols);
                        if (!in_bounds || cell_written[r * MAX_DIM + c])
                            break;
                        r = pick_index(gen_rows, 1'b0);
                        c = pick_index(gen_cols, 1'b0);
                    end
                    if (tries == 8)
                        item_op = mrcr_pkg::OP_WRITE;
                end
            end
            else if (sel < 80)
            begin
                item_op = mrcr_pkg::OP_FLIP_ROW;
                r = pick_index(gen_rows, outside);
                c = $signed(8'($urandom_range(0, 255)));
            end
            else
            begin
                item_op = mrcr_pkg::OP_FLIP_COLUMN;
                r = $signed(8'($urandom_range(0, 255)));
                c = pick_index(gen_cols, outside);
            end
            queue_item(item_op, r, c, 8'($urandom_range(0, 255)));
        end
    endtask

    // one register write over the configuration channel
    task automatic write_count(logic [mrcr_pkg::CfgIdxW-1:0] index,
                               logic [mrcr_pkg::CountW-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == mrcr_pkg::REG_ROW_COUNT)
            gen_rows = usable_count(value);
        else
            gen_cols = usable_count(value);
    endtask

    task automatic set_counts(logic [mrcr_pkg::CountW-1:0] rows,
                              logic [mrcr_pkg::CountW-1:0] cols);
        write_count(mrcr_pkg::REG_ROW_COUNT, rows);
        write_count(mrcr_pkg::REG_COLUMN_COUNT, cols);
        @(negedge clk);
    endtask

    // hold back until every queued item has been answered
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // input driver: offers queued items, with random gaps between transfers
    always @(posedge clk or negedge rst_n)
    begin : item_driver
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_item(current_item));
                if (!quiet_tail && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 13);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    current_item = pending_items.pop_front();
                    op           <= current_item.op;
                    row_index    <= current_item.row_idx;
                    column_index <= current_item.col_idx;
                    cell_value   <= current_item.value;
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result checker and output stall pattern
    always @(posedge clk or negedge rst_n)
    begin : result_checker
        cell_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, read_data %02h bad_index %0b",
                             $time, read_data, bad_index);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (read_data !== want.data)
                    begin
                        $display("%0t: read_data expected %02h actual %02h",
                                 $time, want.data, read_data);
                        mismatch_count++;
                    end
                    if (bad_index !== want.bad)
                    begin
                        $display("%0t: bad_index expected %0b actual %0b",
                                 $time, want.bad, bad_index);
                        mismatch_count++;
                    end
                end
            end
            // one long hold so the block backs up, otherwise short bursts
            if (want_long_hold && !long_hold_done)
            begin
                stall_left     = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 13);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // count registers as seen by the predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_rows <= mrcr_pkg::COUNT_RESET;
            model_cols <= mrcr_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == mrcr_pkg::REG_ROW_COUNT)
                model_rows <= cfg_data;
            else
                model_cols <= cfg_data;
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin : stimulus
        int ph;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners, all-ones and all-zeros bytes, every operation at reset counts
        queue_item(mrcr_pkg::OP_WRITE, 0, 0, 8'h00);
        queue_item(mrcr_pkg::OP_WRITE, 0, 63, 8'hFF);
        queue_item(mrcr_pkg::OP_WRITE, 63, 0, 8'h55);
        queue_item(mrcr_pkg::OP_WRITE, 63, 63, 8'hAA);
        queue_item(mrcr_pkg::OP_WRITE, 0, 1, 8'h01);
        queue_item(mrcr_pkg::OP_READ, 0, 63, 8'h00);
        queue_item(mrcr_pkg::OP_FLIP_ROW, 0, -1, 8'h00);
        queue_item(mrcr_pkg::OP_READ, 0, 0, 8'h00);
        queue_item(mrcr_pkg::OP_FLIP_COLUMN, 127, 0, 8'h00);
        queue_item(mrcr_pkg::OP_READ, 63, 0, 8'h00);
        queue_item(mrcr_pkg::OP_FLIP_ROW, 63, 0, 8'h00);
        queue_item(mrcr_pkg::OP_FLIP_COLUMN, 0, 63, 8'h00);
        queue_item(mrcr_pkg::OP_READ, 63, 63, 8'h00);
        // cell accesses out of range
        queue_item(mrcr_pkg::OP_WRITE, -128, 0, 8'h80);
        queue_item(mrcr_pkg::OP_READ, 127, 0, 8'h00);
        queue_item(mrcr_pkg::OP_READ, 0, 64, 8'h00);
        queue_item(mrcr_pkg::OP_WRITE, 64, -1, 8'h7F);
        // flip indexes out of range
        queue_item(mrcr_pkg::OP_FLIP_ROW, -1, 0, 8'h00);
        queue_item(mrcr_pkg::OP_FLIP_ROW, 64, 0, 8'h00);
        queue_item(mrcr_pkg::OP_FLIP_COLUMN, 0, -128, 8'h00);
        queue_item(mrcr_pkg::OP_FLIP_COLUMN, 0, 127, 8'h00);
        queue_item(mrcr_pkg::OP_READ, 0, 0, 8'h00);
        queue_item(mrcr_pkg::OP_WRITE, 32, 32, 8'h7F);
        queue_item(mrcr_pkg::OP_FLIP_COLUMN, 0, 32, 8'h00);
        queue_item(mrcr_pkg::OP_READ, 31, 32, 8'h00);

        // random traffic while the output is held off for a long stretch
        want_long_hold = 1'b1;
        queue_random(80);
        wait_drained();

        // counts above the matrix size
        set_counts(7'd127, 7'd127);
        queue_random(40);
        wait_drained();

        // empty dimensions
        set_counts(7'd0, 7'd5);
        queue_random(20);
        wait_drained();
        set_counts(7'd9, 7'd0);
        queue_random(20);
        wait_drained();

        // single cell
        set_counts(7'd1, 7'd1);
        queue_random(20);
        wait_drained();

        // small random sizes, odd or even
        for (ph = 0; ph < 4; ph++)
        begin
            set_counts(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)));
            queue_random(40);
            wait_drained();
        end

        // full throughput to the end
        quiet_tail = 1'b1;
        set_counts(7'd64, 7'd63);
        queue_random(40);
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
